// File: design/rse_pkg.sv
// Shared constants, codes and types for the rANS symbol encoder.
package rse_pkg;

   localparam int PROB_BITS        = 12;
   localparam int LOWER_BOUND_BITS = 16;
   localparam int NUM_SYMBOLS      = 256;

   localparam int STATE_W   = 32;
   localparam int FREQ_W    = 13;
   localparam int SYM_W     = 8;
   localparam int WORD_W    = 16;
   localparam int CUM_W     = PROB_BITS;
   localparam int RUN_W     = PROB_BITS + 1;
   localparam int SYM_IDX_W = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
   localparam int THR_W     = FREQ_W + STATE_W;
   localparam int THR_SHIFT = STATE_W - PROB_BITS;
   localparam int DIV_CNT_W = $clog2(STATE_W);

   localparam logic [STATE_W-1:0] STATE_RESET = STATE_W'(1) << LOWER_BOUND_BITS;

   typedef enum logic [1:0] {
      KIND_START  = 2'd0,
      KIND_LOAD   = 2'd1,
      KIND_ENCODE = 2'd2,
      KIND_FLUSH  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      WT_RENORM = 2'd0,
      WT_FINAL  = 2'd1,
      WT_ERROR  = 2'd2
   } word_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_ERROR,
      ST_RENORM,
      ST_DIVIDE,
      ST_UPDATE,
      ST_FLUSH_LO,
      ST_FLUSH_HI
   } fsm_type;

   typedef struct packed {
      logic [FREQ_W-1:0] freq;
      logic [CUM_W-1:0]  cum;
   } entry_type;

endpackage

// File: design/rans_symbol_encoder_top.sv
// rANS encoder: symbol table memory, renormalisation and serial divider.
//
//   channel | direction | beat fields
//   req_*   | in        | kind, symbol, frequency
//   rsp_*   | out       | word, word_type, last
//
// Start and load beats are handled in the idle state; a flush emits two final
// words and a zero-frequency encode emits one error word. An encode reads the
// table, checks the frequency, emits k renormalisation words (k = 0 to 2), runs
// the one-bit-per-cycle restoring divider and makes one state update.
// Reset clears the table valid bits at once; no clearing pass is needed.
// A held output register stalls only the emitting state; a new request beat
// is taken while the last result still waits on rsp_ready.
module rans_symbol_encoder_top
   import rse_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_kind,
   input  logic [SYM_W-1:0]    req_symbol,
   input  logic [FREQ_W-1:0]   req_frequency,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [WORD_W-1:0]   rsp_word,
   output logic [1:0]          rsp_word_type,
   output logic                rsp_last
);

   fsm_type state_ff, state_in;

   entry_type table_mem [NUM_SYMBOLS];
   entry_type rd_ff;
   logic      rd_hit_ff;
   logic [NUM_SYMBOLS-1:0] valid_ff;

   logic [RUN_W-1:0]     run_cum_ff, run_cum_in;
   logic [STATE_W-1:0]   coder_ff, coder_in;
   logic [1:0]           renorm_cnt_ff, renorm_cnt_in;
   logic [STATE_W-1:0]   quo_ff, quo_in;
   logic [FREQ_W-1:0]    rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]    rsp_word_ff, rsp_word_in;
   word_kind_type        rsp_type_ff, rsp_type_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 accept;
   kind_type             kind;
   logic                 sym_in_range;
   logic [SYM_IDX_W-1:0] sym_idx;
   logic                 load_wr;
   logic                 enc_rd;
   logic [FREQ_W-1:0]    cur_freq;
   logic [THR_W-1:0]     thr;
   logic [STATE_W-1:0]   shifted;
   logic                 state_ge_thr;
   logic                 next_ge_thr;
   logic                 renorm_more;
   logic                 slot_free;
   logic [FREQ_W:0]      partial;
   logic [FREQ_W:0]      diff;
   logic                 fits;
   logic [STATE_W-1:0]   new_state;

   logic                 emit;
   logic [WORD_W-1:0]    emit_word;
   word_kind_type        emit_type;
   logic                 emit_last;

   assign req_ready     = (state_ff == ST_IDLE);
   assign accept        = req_valid && req_ready;
   assign kind          = kind_type'(req_kind);
   assign sym_in_range  = {1'b0, req_symbol} < (SYM_W + 1)'(NUM_SYMBOLS);
   assign sym_idx       = req_symbol[SYM_IDX_W-1:0];
   assign load_wr       = accept && (kind == KIND_LOAD) && sym_in_range;
   assign enc_rd        = accept && (kind == KIND_ENCODE);

   // unwritten or out-of-table entries read as frequency zero
   assign cur_freq      = rd_hit_ff ? rd_ff.freq : '0;
   assign thr           = THR_W'(cur_freq) << THR_SHIFT;
   assign shifted       = coder_ff >> LOWER_BOUND_BITS;
   assign state_ge_thr  = THR_W'(coder_ff) >= thr;
   assign next_ge_thr   = THR_W'(shifted) >= thr;
   assign renorm_more   = (renorm_cnt_ff != 2'd2) && state_ge_thr;
   assign slot_free     = !rsp_valid_ff || rsp_ready;

   // one restoring division step
   assign partial       = {rem_ff, quo_ff[STATE_W-1]};
   assign fits          = partial >= {1'b0, cur_freq};
   assign diff          = partial - {1'b0, cur_freq};
   assign new_state     = {quo_ff[STATE_W-PROB_BITS-1:0], {PROB_BITS{1'b0}}}
                          + STATE_W'(rem_ff) + STATE_W'(rd_ff.cum);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && kind == KIND_ENCODE) begin
               state_in = ST_CHECK;
            end else if (accept && kind == KIND_FLUSH) begin
               state_in = ST_FLUSH_LO;
            end
         end
         ST_CHECK: begin
            state_in = (cur_freq == '0) ? ST_ERROR : ST_RENORM;
         end
         ST_ERROR: begin
            if (slot_free) state_in = ST_IDLE;
         end
         ST_RENORM: begin
            if (!renorm_more) state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_cnt_ff == '1) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         ST_FLUSH_LO: begin
            if (slot_free) state_in = ST_FLUSH_HI;
         end
         ST_FLUSH_HI: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      run_cum_in    = run_cum_ff;
      coder_in      = coder_ff;
      renorm_cnt_in = renorm_cnt_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      div_cnt_in    = div_cnt_ff;
      emit          = 1'b0;
      emit_word     = '0;
      emit_type     = WT_RENORM;
      emit_last     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (kind)
                  KIND_START: begin
                     run_cum_in = '0;
                     coder_in   = STATE_RESET;
                  end
                  KIND_LOAD: begin
                     if (sym_in_range) run_cum_in = run_cum_ff + RUN_W'(req_frequency);
                  end
                  KIND_ENCODE: begin
                     renorm_cnt_in = '0;
                  end
                  KIND_FLUSH: begin
                     renorm_cnt_in = renorm_cnt_ff;
                  end
               endcase
            end
         end
         ST_CHECK: begin
            renorm_cnt_in = '0;
         end
         ST_ERROR: begin
            emit      = 1'b1;
            emit_type = WT_ERROR;
            emit_last = 1'b1;
         end
         ST_RENORM: begin
            if (renorm_more) begin
               emit      = 1'b1;
               emit_word = coder_ff[WORD_W-1:0];
               emit_last = (renorm_cnt_ff == 2'd1) || !next_ge_thr;
               if (slot_free) begin
                  coder_in      = shifted;
                  renorm_cnt_in = renorm_cnt_ff + 2'd1;
               end
            end else begin
               quo_in     = coder_ff;
               rem_in     = '0;
               div_cnt_in = '0;
            end
         end
         ST_DIVIDE: begin
            quo_in     = {quo_ff[STATE_W-2:0], fits};
            rem_in     = fits ? diff[FREQ_W-1:0] : partial[FREQ_W-1:0];
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
         end
         ST_UPDATE: begin
            coder_in = new_state;
         end
         ST_FLUSH_LO: begin
            emit      = 1'b1;
            emit_word = coder_ff[WORD_W-1:0];
            emit_type = WT_FINAL;
         end
         ST_FLUSH_HI: begin
            emit      = 1'b1;
            emit_word = coder_ff[STATE_W-1:STATE_W-WORD_W];
            emit_type = WT_FINAL;
            emit_last = 1'b1;
         end
         default: begin
            emit = 1'b0;
         end
      endcase

      // drop the taken beat, load a new one when the slot is free
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      rsp_type_in  = rsp_type_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = emit_word;
         rsp_type_in  = emit_type;
         rsp_last_in  = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         run_cum_ff   <= '0;
         coder_ff     <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         run_cum_ff   <= run_cum_in;
         coder_ff     <= coder_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load_wr) valid_ff[sym_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      renorm_cnt_ff <= renorm_cnt_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      div_cnt_ff    <= div_cnt_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_type_ff   <= rsp_type_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // symbol table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (load_wr) begin
         table_mem[sym_idx] <= '{freq: req_frequency, cum: run_cum_ff[CUM_W-1:0]};
      end
      if (enc_rd) begin
         rd_ff     <= table_mem[sym_idx];
         rd_hit_ff <= valid_ff[sym_idx] && sym_in_range;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_word      = rsp_word_ff;
   assign rsp_word_type = rsp_type_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// File: bench/rans_symbol_encoder_checker.sv
// Checker for the rANS encoder: mirrors the symbol table and coder state, scores result beats.
module rans_symbol_encoder_checker
   import rse_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [1:0]        req_kind,
   input  logic [SYM_W-1:0]  req_symbol,
   input  logic [FREQ_W-1:0] req_frequency,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [WORD_W-1:0] rsp_word,
   input  logic [1:0]        rsp_word_type,
   input  logic              rsp_last,
   output int                mismatches,
   output int                words_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [WORD_W-1:0] word;
      word_kind_type     wtype;
      logic              last;
   } coded_word_type;

   logic [FREQ_W-1:0]  freq_tbl [NUM_SYMBOLS];
   logic [CUM_W-1:0]   cum_tbl  [NUM_SYMBOLS];
   logic [RUN_W-1:0]   cum_acc;
   logic [STATE_W-1:0] coder;
   coded_word_type     coded_q [$];
   int                 err_count = 0;

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      err_count++;
   endtask

   task automatic push_word(input logic [WORD_W-1:0] w, input word_kind_type t,
                            input logic l);
      coded_word_type cw;
      cw.word  = w;
      cw.wtype = t;
      cw.last  = l;
      coded_q.push_back(cw);
   endtask

   // Advance the mirrored encoder by one request beat and queue the words it owes.
   task automatic encode_beat(input kind_type kind, input logic [SYM_W-1:0] sym,
                              input logic [FREQ_W-1:0] freq);
      logic [FREQ_W-1:0]  f;
      logic [CUM_W-1:0]   c;
      logic [THR_W-1:0]   thr;
      logic [WORD_W-1:0]  renorm [2];
      logic [63:0]        quot;
      logic [63:0]        rem;
      logic [63:0]        next;
      int                 n;
      f = '0;
      c = '0;
      n = 0;
      case (kind)
         KIND_START: begin
            cum_acc = '0;
            coder   = STATE_RESET;
         end
         KIND_LOAD: begin
            if (int'(sym) < NUM_SYMBOLS) begin
               freq_tbl[sym] = freq;
               cum_tbl[sym]  = cum_acc[CUM_W-1:0];
               cum_acc       = cum_acc + RUN_W'(freq);
            end
         end
         KIND_ENCODE: begin
            if (int'(sym) < NUM_SYMBOLS) begin
               f = freq_tbl[sym];
               c = cum_tbl[sym];
            end
            if (f == '0) begin
               push_word('0, WT_ERROR, 1'b1);
            end else begin
               thr = THR_W'(f) << THR_SHIFT;
               while (n < 2 && THR_W'(coder) >= thr) begin
                  renorm[n] = coder[WORD_W-1:0];
                  coder     = coder >> LOWER_BOUND_BITS;
                  n++;
               end
               for (int i = 0; i < n; i++)
                  push_word(renorm[i], WT_RENORM, i == n - 1);
               quot  = 64'(coder) / 64'(f);
               rem   = 64'(coder) % 64'(f);
               next  = (quot << PROB_BITS) + rem + 64'(c);
               coder = next[STATE_W-1:0];
            end
         end
         default: begin
            push_word(coder[WORD_W-1:0], WT_FINAL, 1'b0);
            push_word(coder[STATE_W-1:WORD_W], WT_FINAL, 1'b1);
         end
      endcase
   endtask

   always @(posedge clock) begin
      coded_word_type exp_word;
      if (reset) begin
         for (int i = 0; i < NUM_SYMBOLS; i++) begin
            freq_tbl[i] = '0;
            cum_tbl[i]  = '0;
         end
         cum_acc = '0;
         coder   = STATE_RESET;
         coded_q.delete();
      end else begin
         // score the result beat first: it always belongs to an older request
         if (rsp_valid && rsp_ready) begin
            if (coded_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result beat word %h type %0d last %b",
                                         rsp_word, rsp_word_type, rsp_last));
            end else begin
               exp_word = coded_q.pop_front();
               if (rsp_word !== exp_word.word)
                  report_mismatch($sformatf("word %h, want %h", rsp_word, exp_word.word));
               if (rsp_word_type !== exp_word.wtype)
                  report_mismatch($sformatf("word_type %0d, want %0d", rsp_word_type,
                                            exp_word.wtype));
               if (rsp_last !== exp_word.last)
                  report_mismatch($sformatf("last %b, want %b", rsp_last, exp_word.last));
            end
         end
         if (req_valid && req_ready)
            encode_beat(kind_type'(req_kind), req_symbol, req_frequency);
      end
      mismatches <= err_count;
      words_owed <= coded_q.size();
   end

endmodule

// File: bench/rans_symbol_encoder_top_test.sv
// Testbench top for the rANS encoder: request stimulus, result back-pressure and verdict.
module rans_symbol_encoder_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import rse_pkg::*;

   localparam int ITEM_TARGET   = 600;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 64;

   logic              clock         = 1'b0;
   logic              reset         = 1'b1;
   logic              req_valid     = 1'b0;
   logic              req_ready;
   logic [1:0]        req_kind      = KIND_START;
   logic [SYM_W-1:0]  req_symbol    = '0;
   logic [FREQ_W-1:0] req_frequency = '0;
   logic              rsp_valid;
   logic              rsp_ready     = 1'b0;
   logic [WORD_W-1:0] rsp_word;
   logic [1:0]        rsp_word_type;
   logic              rsp_last;

   int mismatches;
   int words_owed;
   int tx_idle_pct = 33;
   int rx_idle_pct = 56;
   int beats_sent  = 0;
   int cycle_count = 0;

   rans_symbol_encoder_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_symbol    (req_symbol),
      .req_frequency (req_frequency),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_word      (rsp_word),
      .rsp_word_type (rsp_word_type),
      .rsp_last      (rsp_last)
   );

   rans_symbol_encoder_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_symbol    (req_symbol),
      .req_frequency (req_frequency),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_word      (rsp_word),
      .rsp_word_type (rsp_word_type),
      .rsp_last      (rsp_last),
      .mismatches    (mismatches),
      .words_owed    (words_owed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("rans_symbol_encoder_top_test failed");
         $finish;
      end
   end

   task automatic send_beat(input kind_type kind, input logic [SYM_W-1:0] sym,
                            input logic [FREQ_W-1:0] freq);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_symbol    <= sym;
      req_frequency <= freq;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
      if (beats_sent >= 2 * ITEM_TARGET / 3) begin
         tx_idle_pct = 0;
         rx_idle_pct = 0;
      end else if (beats_sent >= ITEM_TARGET / 3) begin
         tx_idle_pct = 56;
         rx_idle_pct = 33;
      end
   endtask

   // Lean on the extremes: zero and the full 4096 turn up often.
   function automatic logic [FREQ_W-1:0] rand_freq();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return FREQ_W'(4096);
         default: return FREQ_W'($urandom_range(0, 4096));
      endcase
   endfunction

   // One block: usually a start, ascending table load, encodes mostly of loaded symbols, usually a flush.
   task automatic run_block();
      logic [SYM_W-1:0]  loaded [$];
      logic [SYM_W-1:0]  sym;
      logic [FREQ_W-1:0] f;
      int n_ent;
      int cur;
      int room;
      int left;
      int n_left;
      int cap;
      int pick;
      int n_enc;
      bit wild;
      n_ent = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 40) : $urandom_range(2, 12);
      wild  = ($urandom_range(0, 3) == 0);
      left  = 4096;
      if ($urandom_range(0, 9) != 0)
         send_beat(KIND_START, SYM_W'($urandom), FREQ_W'($urandom));
      cur = $urandom_range(0, NUM_SYMBOLS - n_ent);
      for (int i = 0; i < n_ent; i++) begin
         if (i > 0) begin
            room = (NUM_SYMBOLS - 1) - cur - (n_ent - 1 - i);
            cur  = cur + 1 + $urandom_range(0, (room - 1 < 20) ? room - 1 : 20);
         end
         if (wild) begin
            f = rand_freq();
         end else begin
            // split the 4096 total, now and then dropping an entry to zero
            n_left = n_ent - i;
            if (n_left == 1) begin
               pick = left;
            end else begin
               pick = $urandom_range(1, (2 * left) / n_left);
               cap  = left - (n_left - 1);
               if (pick > cap)
                  pick = cap;
            end
            if ($urandom_range(0, 9) == 0) begin
               f = '0;
            end else begin
               f    = FREQ_W'(pick);
               left = left - pick;
            end
         end
         loaded.push_back(SYM_W'(cur));
         send_beat(KIND_LOAD, SYM_W'(cur), f);
      end
      n_enc = $urandom_range(4, 24);
      for (int i = 0; i < n_enc; i++) begin
         if ($urandom_range(0, 9) != 0)
            sym = loaded[$urandom_range(0, loaded.size() - 1)];
         else
            sym = SYM_W'($urandom);
         send_beat(KIND_ENCODE, sym, FREQ_W'($urandom));
      end
      if ($urandom_range(0, 9) != 0)
         send_beat(KIND_FLUSH, SYM_W'($urandom), FREQ_W'($urandom));
   endtask

   initial begin
      int n_noise;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty table after reset, then the reset state flushed
      send_beat(KIND_ENCODE, 8'd0,   13'd0);
      send_beat(KIND_FLUSH,  8'd0,   13'd0);
      send_beat(KIND_START,  8'd255, 13'd4096);
      send_beat(KIND_LOAD,   8'd0,   13'd0);
      send_beat(KIND_LOAD,   8'd1,   13'd4096);
      send_beat(KIND_LOAD,   8'd2,   13'd1);
      send_beat(KIND_LOAD,   8'd128, 13'd2048);
      send_beat(KIND_LOAD,   8'd255, 13'd4095);
      // full-scale symbol never renormalises; frequency one renormalises soon
      send_beat(KIND_ENCODE, 8'd1,   13'd0);
      send_beat(KIND_ENCODE, 8'd2,   13'd8191);
      send_beat(KIND_ENCODE, 8'd2,   13'd0);
      send_beat(KIND_ENCODE, 8'd0,   13'd0);
      send_beat(KIND_ENCODE, 8'd77,  13'd0);
      send_beat(KIND_ENCODE, 8'd255, 13'd0);
      send_beat(KIND_ENCODE, 8'd128, 13'd0);
      send_beat(KIND_ENCODE, 8'd2,   13'd0);
      send_beat(KIND_ENCODE, 8'd128, 13'd0);
      send_beat(KIND_FLUSH,  8'd255, 13'd8191);
      // restart keeps the table
      send_beat(KIND_START,  8'd0,   13'd0);
      send_beat(KIND_ENCODE, 8'd255, 13'd0);
      send_beat(KIND_FLUSH,  8'd0,   13'd0);

      while (beats_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 99) < 8) begin
            n_noise = $urandom_range(1, 3);
            for (int i = 0; i < n_noise; i++)
               send_beat(kind_type'($urandom_range(0, 3)), SYM_W'($urandom), rand_freq());
         end
         run_block();
      end
      req_valid <= 1'b0;

      // drain, then let any word-less encode finish
      @(posedge clock);
      while (words_owed != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("rans_symbol_encoder_top_test passed");
      else
         $display("rans_symbol_encoder_top_test failed");
      $finish;
   end

endmodule
